// ===== hw/rtl/svde_pkg.sv =====
// ----------------------------------------------------------------------------
// svde_pkg: shared definitions of the stream variable-byte delta encoder
// Register indexes, mode codes, size thresholds and the coded-length type.
// ----------------------------------------------------------------------------
package svde_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ENCODE_MODE  = 2'd0;
    localparam logic [1:0] REG_DELTA_ENABLE = 2'd1;
    localparam logic [1:0] REG_DELTA_BASE   = 2'd2;

    // Encode modes; the unused code behaves as the plain mode
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_ZIGZAG = 2'd1;
    localparam logic [1:0] MODE_0124   = 2'd2;

    // Field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned ACC_W   = 6;

    // Byte-size thresholds
    localparam logic [VALUE_W-1:0] LIMIT_1B = 32'h0000_0100;
    localparam logic [VALUE_W-1:0] LIMIT_2B = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] LIMIT_3B = 32'h0100_0000;

    // Length code and byte count of one value
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_code_len;

    // Zigzag map: sign moves to bit zero
    function automatic logic [VALUE_W-1:0] zigzag(input logic [VALUE_W-1:0] v);
        zigzag = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    // Length of a value in 1/2/3/4-byte coding
    function automatic t_code_len classify_1234(input logic [VALUE_W-1:0] v);
        t_code_len c;
        if (v < LIMIT_1B) begin
            c = '{code: 2'd0, len: 3'd1};
        end else if (v < LIMIT_2B) begin
            c = '{code: 2'd1, len: 3'd2};
        end else if (v < LIMIT_3B) begin
            c = '{code: 2'd2, len: 3'd3};
        end else begin
            c = '{code: 2'd3, len: 3'd4};
        end
        classify_1234 = c;
    endfunction

    // Length of a value in 0/1/2/4-byte coding
    function automatic t_code_len classify_0124(input logic [VALUE_W-1:0] v);
        t_code_len c;
        if (v == '0) begin
            c = '{code: 2'd0, len: 3'd0};
        end else if (v < LIMIT_1B) begin
            c = '{code: 2'd1, len: 3'd1};
        end else if (v < LIMIT_2B) begin
            c = '{code: 2'd2, len: 3'd2};
        end else begin
            c = '{code: 2'd3, len: 3'd4};
        end
        classify_0124 = c;
    endfunction

endpackage

// ===== hw/rtl/stream_vbyte_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// stream_vbyte_delta_encoder: variable-byte encoder with delta and zigzag
// Codes 32-bit values as data bytes plus packed 2-bit length keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) transfers one value and its
//   block_end flag. Output channel (o_out_valid / i_out_ready) transfers one
//   result per value: data word and length, key byte with its valid flag,
//   and the end-of-block flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
//   writes encode_mode (0), delta_enable (1) or delta_base (2); index 3 is
//   ignored. Write it only while the block is idle.
//   A result passes through one input register, then the result register.
//   Throughput is one value per cycle while the receiver takes each result,
//   set by the single subtract, compare and pack step between the two.
//   A key byte comes out with every fourth value and with each block end.
//   Reset clears the configuration and state registers, the key slot and
//   the pipeline, and the next value starts a block. When the receiver
//   stalls, the result register holds and the input register still takes
//   one more value, after which o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module stream_vbyte_delta_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_value,
    input  logic        i_block_end,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_data_word,
    output logic [2:0]  o_data_len,
    output logic [7:0]  o_key_byte,
    output logic        o_key_valid,
    output logic        o_end_of_block,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers
    logic [1:0]  r_encode_mode;
    logic        r_delta_enable;
    logic [31:0] r_delta_base;

    // Encoder state
    logic [31:0] r_prev_value;
    logic [5:0]  r_key_acc;
    logic [1:0]  r_slot;
    logic        r_block_start;

    // Input register
    logic        r_in_valid;
    logic [31:0] r_in_value;
    logic        r_in_block_end;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_data_word;
    logic [2:0]  r_data_len;
    logic [7:0]  r_key_byte;
    logic        r_key_valid;
    logic        r_end_of_block;

    // Combinational step
    logic                  out_free;
    logic                  advance;
    logic [31:0]           prev;
    logic [31:0]           diff;
    logic [31:0]           coded;
    svde_pkg::t_code_len   cl;
    logic [31:0]           n_data_word;
    logic [7:0]            key_full;
    logic [5:0]            n_key_acc;
    logic                  emit;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || out_free;
    assign advance     = r_in_valid && out_free;

    // Difference, optional zigzag, and length classification
    always_comb begin
        prev  = r_block_start ? r_delta_base : r_prev_value;
        diff  = r_delta_enable ? (r_in_value - prev) : r_in_value;
        coded = diff;
        if (r_encode_mode == svde_pkg::MODE_0124) begin
            cl = svde_pkg::classify_0124(diff);
        end else begin
            if (r_encode_mode == svde_pkg::MODE_ZIGZAG) begin
                coded = svde_pkg::zigzag(diff);
            end
            cl = svde_pkg::classify_1234(coded);
        end
    end

    // Keep only the data bytes that the length covers
    always_comb begin
        case (cl.len)
            3'd0:    n_data_word = '0;
            3'd1:    n_data_word = {24'd0, coded[7:0]};
            3'd2:    n_data_word = {16'd0, coded[15:0]};
            3'd3:    n_data_word = {8'd0, coded[23:0]};
            default: n_data_word = coded;
        endcase
    end

    // Key packing: insert the code at the current slot
    always_comb begin
        emit = (r_slot == 2'd3) || r_in_block_end;
        case (r_slot)
            2'd0: begin
                key_full  = {6'd0, cl.code};
                n_key_acc = {4'd0, cl.code};
            end
            2'd1: begin
                key_full  = {4'd0, cl.code, r_key_acc[1:0]};
                n_key_acc = {2'd0, cl.code, r_key_acc[1:0]};
            end
            2'd2: begin
                key_full  = {2'd0, cl.code, r_key_acc[3:0]};
                n_key_acc = {cl.code, r_key_acc[3:0]};
            end
            default: begin
                key_full  = {cl.code, r_key_acc};
                n_key_acc = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encode_mode  <= svde_pkg::MODE_PLAIN;
            r_delta_enable <= 1'b0;
            r_delta_base   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                svde_pkg::REG_ENCODE_MODE:  r_encode_mode  <= i_cfg_data[1:0];
                svde_pkg::REG_DELTA_ENABLE: r_delta_enable <= i_cfg_data[0];
                svde_pkg::REG_DELTA_BASE:   r_delta_base   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_value     <= i_value;
            r_in_block_end <= i_block_end;
        end
    end

    // Encoder state update as each value moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_value  <= '0;
            r_key_acc     <= '0;
            r_slot        <= '0;
            r_block_start <= 1'b1;
        end else if (advance) begin
            r_prev_value  <= r_in_block_end ? r_delta_base : r_in_value;
            r_block_start <= r_in_block_end;
            if (emit) begin
                r_key_acc <= '0;
                r_slot    <= '0;
            end else begin
                r_key_acc <= n_key_acc;
                r_slot    <= r_slot + 2'd1;
            end
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data_word    <= n_data_word;
            r_data_len     <= cl.len;
            r_key_byte     <= emit ? key_full : 8'd0;
            r_key_valid    <= emit;
            r_end_of_block <= r_in_block_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_word    = r_data_word;
    assign o_data_len     = r_data_len;
    assign o_key_byte     = r_key_byte;
    assign o_key_valid    = r_key_valid;
    assign o_end_of_block = r_end_of_block;

`ifndef SYNTHESIS
    // A block end always flushes a key byte.
    a_eob_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_end_of_block) |-> r_key_valid)
        else $error("block end without key byte");

    // An incomplete key is never shown.
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_key_valid) |-> (r_key_byte == 8'd0))
        else $error("key byte nonzero while not valid");

    // After a block end the key slot restarts and the next value starts a block.
    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_block_end) |=> (r_slot == 2'd0 && r_key_acc == 6'd0
                                         && r_block_start))
        else $error("state not restarted after block end");

    // Bytes above a one-byte data length are zero.
    a_len_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_data_len == 3'd1) |-> (r_data_word[31:8] == 24'd0))
        else $error("data word bytes above length not zero");
`endif

endmodule
